[rtl/cmdtok_pkg.sv]
package cmdtok_pkg;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_QUO = 8'h22;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    // One result item
    typedef struct packed {
        logic [7:0]  slash_run;
        logic [7:0]  out_char;
        logic        char_valid;
        logic        arg_end;
        logic        line_end;
        logic [15:0] arg_count;
        logic [15:0] total_length;
        logic        overflow;
    } result_t;

endpackage

[rtl/cmdtok_if.sv]
interface cmdtok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       line_last;

    modport source (output valid, output in_byte, output line_last, input ready);
    modport sink (input valid, input in_byte, input line_last, output ready);
endinterface

interface cmdtok_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  slash_run;
    logic [7:0]  out_char;
    logic        char_valid;
    logic        arg_end;
    logic        line_end;
    logic [15:0] arg_count;
    logic [15:0] total_length;
    logic        overflow;

    modport source (
        output valid, output slash_run, output out_char, output char_valid,
        output arg_end, output line_end, output arg_count, output total_length,
        output overflow, input ready
    );
    modport sink (
        input valid, input slash_run, input out_char, input char_valid,
        input arg_end, input line_end, input arg_count, input total_length,
        input overflow, output ready
    );
endinterface

[rtl/command_line_tokenizer.sv]
// A result is registered in the output slot, or in the skid slot while the output stalls, before it is offered.
// Input takes one byte per cycle while the skid slot is empty; the parser state updates once per accepted byte.
// A two-slot output buffer (output and skid slots) lets input take one more byte while the output stalls.
// Reset (rst_n low, asynchronous) clears the parser state and empties the buffer.
module command_line_tokenizer #(
    parameter int SLASH_BITS = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    cmdtok_in_if.sink           in_ch,
    cmdtok_out_if.source        out_ch
);
    import cmdtok_pkg::*;

    result_t res;
    result_t buf_data;
    logic    in_ready;
    logic    accept;

    assign in_ch.ready = in_ready;
    assign accept      = in_ch.valid && in_ready;

    cmdtok_core #(
        .SLASH_BITS(SLASH_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_ch.in_byte),
        .line_last(in_ch.line_last),
        .res      (res)
    );

    cmdtok_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .in_data  (res),
        .out_valid(out_ch.valid),
        .out_ready(out_ch.ready),
        .out_data (buf_data)
    );

    // Drive the result fields
    assign out_ch.slash_run    = buf_data.slash_run;
    assign out_ch.out_char     = buf_data.out_char;
    assign out_ch.char_valid   = buf_data.char_valid;
    assign out_ch.arg_end      = buf_data.arg_end;
    assign out_ch.line_end     = buf_data.line_end;
    assign out_ch.arg_count    = buf_data.arg_count;
    assign out_ch.total_length = buf_data.total_length;
    assign out_ch.overflow     = buf_data.overflow;

endmodule

[rtl/cmdtok_core.sv]
module cmdtok_core #(
    parameter int SLASH_BITS = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                line_last,
    output cmdtok_pkg::result_t res
);
    import cmdtok_pkg::*;

    localparam logic [SLASH_BITS-1:0] SLASH_MAX = {SLASH_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam int SUM_BITS = ((COUNT_BITS > SLASH_BITS + 1) ? COUNT_BITS : SLASH_BITS + 1) + 1;

    logic                  in_quote_reg, in_quote_next;
    logic                  closed_reg, closed_next;
    logic                  token_reg, token_next;
    logic [SLASH_BITS-1:0] pend_reg, pend_next;
    logic [COUNT_BITS-1:0] args_reg, args_next;
    logic [COUNT_BITS-1:0] bytes_reg, bytes_next;
    logic                  sat_reg, sat_next;

    // Work out the result and the state left behind for one byte
    always_comb
    begin
        logic                  iq;
        logic                  tok;
        logic [SLASH_BITS-1:0] pend;
        logic [COUNT_BITS-1:0] args;
        logic [COUNT_BITS-1:0] bytes;
        logic                  sat;
        logic                  qjc;
        logic                  open_tok;
        logic [SLASH_BITS-1:0] run;
        logic [7:0]            ch;
        logic                  valid;
        logic                  aend;
        logic [SLASH_BITS:0]   n;
        logic [SUM_BITS-1:0]   sum;
        logic                  blank;

        iq       = in_quote_reg;
        tok      = token_reg;
        pend     = pend_reg;
        args     = args_reg;
        bytes    = bytes_reg;
        sat      = sat_reg;
        qjc      = 1'b0;
        open_tok = 1'b0;
        run      = '0;
        ch       = 8'h00;
        valid    = 1'b0;
        aend     = 1'b0;
        blank    = (in_byte == CH_SP) || (in_byte == CH_TAB);

        if (closed_reg && in_byte == CH_QUO)
        begin
            // quote right after a closing quote is literal
            open_tok = 1'b1;
            ch       = CH_QUO;
            valid    = 1'b1;
        end
        else if (in_byte == CH_BSL)
        begin
            // hold the backslash, saturating the run
            open_tok = 1'b1;
            if (pend == SLASH_MAX)
                sat = 1'b1;
            else
                pend = pend + 1'b1;
        end
        else if (in_byte == CH_QUO)
        begin
            // emit half the run; parity picks literal or toggle
            open_tok = 1'b1;
            run      = pend >> 1;
            pend     = '0;
            if (pend_reg[0])
            begin
                ch    = CH_QUO;
                valid = 1'b1;
            end
            else if (iq)
            begin
                iq  = 1'b0;
                qjc = 1'b1;
            end
            else
                iq = 1'b1;
        end
        else if (blank && !iq)
        begin
            // separator closes an open argument
            if (tok)
            begin
                run  = pend;
                pend = '0;
                aend = 1'b1;
                tok  = 1'b0;
            end
        end
        else
        begin
            open_tok = 1'b1;
            run      = pend;
            pend     = '0;
            ch       = in_byte;
            valid    = 1'b1;
        end

        // start a new argument
        if (open_tok && !tok)
        begin
            tok = 1'b1;
            if (args == COUNT_MAX)
                sat = 1'b1;
            else
                args = args + 1'b1;
        end

        // flush held backslashes and close the argument at end of line
        if (line_last)
        begin
            if (pend != '0)
            begin
                run  = pend;
                pend = '0;
            end
            if (tok)
            begin
                aend = 1'b1;
                tok  = 1'b0;
            end
        end

        // add output bytes, saturating
        n   = {1'b0, run} + (SLASH_BITS + 1)'(valid) + (SLASH_BITS + 1)'(aend);
        sum = SUM_BITS'(bytes) + SUM_BITS'(n);
        if (sum > SUM_BITS'(COUNT_MAX))
        begin
            bytes = COUNT_MAX;
            sat   = 1'b1;
        end
        else
            bytes = COUNT_BITS'(sum);

        res.slash_run    = 8'(run);
        res.out_char     = ch;
        res.char_valid   = valid;
        res.arg_end      = aend;
        res.line_end     = line_last;
        res.arg_count    = 16'(args);
        res.total_length = 16'(bytes);
        res.overflow     = sat;

        if (line_last)
        begin
            in_quote_next = 1'b0;
            closed_next   = 1'b0;
            token_next    = 1'b0;
            pend_next     = '0;
            args_next     = '0;
            bytes_next    = '0;
            sat_next      = 1'b0;
        end
        else
        begin
            in_quote_next = iq;
            closed_next   = qjc;
            token_next    = tok;
            pend_next     = pend;
            args_next     = args;
            bytes_next    = bytes;
            sat_next      = sat;
        end
    end

    // Advance the parser state on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quote_reg <= 1'b0;
            closed_reg   <= 1'b0;
            token_reg    <= 1'b0;
            pend_reg     <= '0;
            args_reg     <= '0;
            bytes_reg    <= '0;
            sat_reg      <= 1'b0;
        end
        else if (accept)
        begin
            in_quote_reg <= in_quote_next;
            closed_reg   <= closed_next;
            token_reg    <= token_next;
            pend_reg     <= pend_next;
            args_reg     <= args_next;
            bytes_reg    <= bytes_next;
            sat_reg      <= sat_next;
        end
    end

endmodule

[rtl/cmdtok_outbuf.sv]
module cmdtok_outbuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cmdtok_pkg::result_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cmdtok_pkg::result_t out_data
);
    import cmdtok_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    push;
    logic    pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid_reg && out_ready;

    // Track occupancy of the output and skid slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push && !(out_valid_reg && !pop))
            out_valid_reg <= 1'b1;
        else if (push)
            skid_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    // Move payload into the output slot or hold it in the skid slot
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push && !(out_valid_reg && !pop))
            out_data_reg <= in_data;
        else if (push)
            skid_data_reg <= in_data;
    end

endmodule

[rtl/cmdtok_checker.sv]
module cmdtok_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  slash_run,
    input logic [7:0]  out_char,
    input logic        char_valid,
    input logic [15:0] arg_count,
    input logic [15:0] total_length
);

    // A stalled result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its contents
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(slash_run) && $stable(out_char)
            && $stable(arg_count) && $stable(total_length))
        else $error("result changed while stalled");

    // No character means a zero character field
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_valid |-> out_char == 8'h00)
        else $error("out_char nonzero without char_valid");

    // Input backpressure only when a result is waiting
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

endmodule

bind command_line_tokenizer cmdtok_checker u_cmdtok_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .slash_run   (out_ch.slash_run),
    .out_char    (out_ch.out_char),
    .char_valid  (out_ch.char_valid),
    .arg_count   (out_ch.arg_count),
    .total_length(out_ch.total_length)
);
